### rtl/core/svme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svme_pkg
// Shared types, field widths and helpers of the sparse vector merge engine.
// ----------------------------------------------------------------------------
package svme_pkg;

  localparam int unsigned IdxW  = 20;  // index field width
  localparam int unsigned ValW  = 32;  // Q16.16 value width
  localparam int unsigned WideW = 56;  // wide accumulator width

  // mode register codes
  localparam logic [1:0] ModeDot  = 2'd0;
  localparam logic [1:0] ModeAxpy = 2'd1;
  localparam logic [1:0] ModeNorm = 2'd2;

  // register indexes
  localparam logic RegMode  = 1'b0;
  localparam logic RegScale = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;   // input request accepted
    logic read;   // read both stores at the pointers
    logic mul;    // register the product
    logic step;   // commit one merge step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_pending;  // both vectors closed
    logic emit;         // this step produces a result
    logic done;         // this step ends the run
    logic out_free;     // output register can take a result
  } status_t;

  // clamp a wide signed value to Q16.16, flag in the top bit
  function automatic logic [ValW:0] sat_q16(input logic signed [WideW-1:0] v);
    logic [ValW:0] r;
    if (v > WideW'(signed'(33'sh0_7FFF_FFFF))) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < WideW'(signed'(33'sh1_8000_0000))) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[ValW-1:0]};
    end
    return r;
  endfunction

endpackage

### rtl/core/svme_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svme_in_if / svme_out_if
// Valid/ready channels for entry requests and result requests.
// ----------------------------------------------------------------------------
interface svme_in_if;
  logic                        valid;
  logic                        ready;
  logic                        which_vector;
  logic                        carries_entry;
  logic [svme_pkg::IdxW-1:0]   entry_index;
  logic signed [svme_pkg::ValW-1:0] entry_value;
  logic                        closes_vector;

  modport source (output valid, which_vector, carries_entry, entry_index,
                  entry_value, closes_vector, input ready);
  modport sink   (input valid, which_vector, carries_entry, entry_index,
                  entry_value, closes_vector, output ready);
endinterface

interface svme_out_if;
  logic                        valid;
  logic                        ready;
  logic [svme_pkg::IdxW-1:0]   out_index;
  logic signed [svme_pkg::ValW-1:0] out_value;
  logic                        saturated;
  logic                        final_result;

  modport source (output valid, out_index, out_value, saturated, final_result,
                  input ready);
  modport sink   (input valid, out_index, out_value, saturated, final_result,
                  output ready);
endinterface

### rtl/core/svme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svme_ctrl
// Sequencer: loads entries, then walks the merge read/multiply/step.
// ----------------------------------------------------------------------------
module svme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  svme_pkg::status_t status_i,
  output svme_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_EVAL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == S_LOAD) && !status_i.run_pending;
    cmd_o.load = in_ready_o && in_valid_i;
    cmd_o.read = (state_q == S_READ);
    cmd_o.mul  = (state_q == S_MUL);
    cmd_o.step = (state_q == S_EVAL) && (!status_i.emit || status_i.out_free);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (status_i.run_pending) state_d = S_READ;
      S_READ: state_d = S_MUL;
      S_MUL:  state_d = S_EVAL;
      S_EVAL: begin
        if (cmd_o.step) state_d = status_i.done ? S_LOAD : S_READ;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/svme_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svme_dp
// Entry stores, merge pointers, shared multiplier, accumulators, result reg.
// ----------------------------------------------------------------------------
module svme_dp #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  svme_pkg::cmd_t              cmd_i,
  output svme_pkg::status_t           status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [svme_pkg::ValW-1:0]   cfg_data_i,
  input  logic                        which_vector_i,
  input  logic                        carries_entry_i,
  input  logic [svme_pkg::IdxW-1:0]   entry_index_i,
  input  logic [svme_pkg::ValW-1:0]   entry_value_i,
  input  logic                        closes_vector_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [svme_pkg::IdxW-1:0]   out_index_o,
  output logic [svme_pkg::ValW-1:0]   out_value_o,
  output logic                        saturated_o,
  output logic                        final_result_o
);

  localparam int unsigned IW = (INDEX_BITS < svme_pkg::IdxW) ? INDEX_BITS : svme_pkg::IdxW;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = svme_pkg::ValW;
  localparam int unsigned WW = svme_pkg::WideW;

  // stores
  logic [IW-1:0] x_idx_mem [DEPTH];
  logic [VW-1:0] x_val_mem [DEPTH];
  logic [IW-1:0] y_idx_mem [DEPTH];
  logic [VW-1:0] y_val_mem [DEPTH];

  logic [CW-1:0] x_cnt_q, y_cnt_q, i_q, j_q;
  logic          x_closed_q, y_closed_q;
  logic [1:0]    mode_q;
  logic [VW-1:0] scale_q;

  logic [IW-1:0] xi_q, yi_q;
  logic [VW-1:0] xv_q, yv_q;
  logic signed [47:0] prod_q;
  logic signed [WW-1:0] acc_q;
  logic [VW:0]   best_q;

  logic          out_valid_q, sat_q, fin_q;
  logic [svme_pkg::IdxW-1:0] oidx_q;
  logic [VW-1:0] oval_q;

  logic wr_x, wr_y;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= svme_pkg::ModeDot;
      scale_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == svme_pkg::RegMode) mode_q <= cfg_data_i[1:0];
      else                                scale_q <= cfg_data_i;
    end
  end

  // load path
  assign wr_x = cmd_i.load && !which_vector_i && !x_closed_q && carries_entry_i
                && (x_cnt_q < CW'(DEPTH));
  assign wr_y = cmd_i.load && which_vector_i && !y_closed_q && carries_entry_i
                && (y_cnt_q < CW'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_x) begin
      x_idx_mem[x_cnt_q[AW-1:0]] <= entry_index_i[IW-1:0];
      x_val_mem[x_cnt_q[AW-1:0]] <= entry_value_i;
    end
    if (wr_y) begin
      y_idx_mem[y_cnt_q[AW-1:0]] <= entry_index_i[IW-1:0];
      y_val_mem[y_cnt_q[AW-1:0]] <= entry_value_i;
    end
    if (cmd_i.read) begin
      xi_q <= x_idx_mem[i_q[AW-1:0]];
      xv_q <= x_val_mem[i_q[AW-1:0]];
      yi_q <= y_idx_mem[j_q[AW-1:0]];
      yv_q <= y_val_mem[j_q[AW-1:0]];
    end
  end

  // shared multiplier, floor of the Q16.16 product
  logic signed [63:0] prod_full;
  always_comb begin
    if (mode_q == svme_pkg::ModeAxpy) begin
      prod_full = signed'(scale_q) * signed'(xv_q);
    end else begin
      prod_full = signed'(xv_q) * signed'(yv_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= prod_full[63:16];
  end

  // merge step evaluation
  logic ax, ay, x_lt, y_lt, lst_x, lst_y;
  logic emit, done, adv_i, adv_j, fin;
  logic signed [WW-1:0] acc_d, val_w;
  logic [VW:0] best_d, xabs;
  logic [VW:0] sat_r;
  logic [svme_pkg::IdxW-1:0] idx_w;

  always_comb begin
    ax    = i_q < x_cnt_q;
    ay    = j_q < y_cnt_q;
    x_lt  = xi_q < yi_q;
    y_lt  = yi_q < xi_q;
    lst_x = CW'(i_q + 1'b1) >= x_cnt_q;
    lst_y = CW'(j_q + 1'b1) >= y_cnt_q;
    xabs  = xv_q[VW-1] ? (VW+1)'(-signed'({xv_q[VW-1], xv_q}))
                       : {1'b0, xv_q};
    emit  = 1'b0;
    done  = 1'b0;
    adv_i = 1'b0;
    adv_j = 1'b0;
    fin   = 1'b1;
    acc_d = acc_q;
    best_d = best_q;
    val_w = acc_q;
    idx_w = '0;
    case (mode_q)
      svme_pkg::ModeAxpy: begin
        if (!ax && !ay) begin
          done = 1'b1;
        end else if (!ay || (ax && x_lt)) begin
          emit  = 1'b1;
          adv_i = 1'b1;
          fin   = lst_x && !ay;
          val_w = WW'(prod_q);
          idx_w[IW-1:0] = xi_q;
        end else if (!ax || y_lt) begin
          emit  = 1'b1;
          adv_j = 1'b1;
          fin   = !ax && lst_y;
          val_w = WW'(signed'(yv_q));
          idx_w[IW-1:0] = yi_q;
        end else begin
          emit  = 1'b1;
          adv_i = 1'b1;
          adv_j = 1'b1;
          fin   = lst_x && lst_y;
          val_w = WW'(prod_q) + WW'(signed'(yv_q));
          idx_w[IW-1:0] = xi_q;
        end
        if (emit) done = fin;
      end
      svme_pkg::ModeNorm: begin
        if (ax) begin
          adv_i = 1'b1;
          if (xabs > best_q) best_d = xabs;
        end else begin
          emit  = 1'b1;
          done  = 1'b1;
          val_w = WW'(signed'({1'b0, best_q}));
        end
      end
      default: begin
        if (ax && ay) begin
          if (x_lt) begin
            adv_i = 1'b1;
          end else if (y_lt) begin
            adv_j = 1'b1;
          end else begin
            adv_i = 1'b1;
            adv_j = 1'b1;
            acc_d = acc_q + WW'(prod_q);
          end
        end else begin
          emit = 1'b1;
          done = 1'b1;
        end
      end
    endcase
    sat_r = svme_pkg::sat_q16(val_w);
  end

  assign status_o = '{run_pending: x_closed_q && y_closed_q,
                      emit:        emit,
                      done:        done,
                      out_free:    !out_valid_q || out_ready_i};

  // pointers, counts and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cnt_q    <= '0;
      y_cnt_q    <= '0;
      x_closed_q <= 1'b0;
      y_closed_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      acc_q      <= '0;
      best_q     <= '0;
    end else if (cmd_i.step && done) begin
      x_cnt_q    <= '0;
      y_cnt_q    <= '0;
      x_closed_q <= 1'b0;
      y_closed_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      acc_q      <= '0;
      best_q     <= '0;
    end else if (cmd_i.step) begin
      if (adv_i) i_q <= CW'(i_q + 1'b1);
      if (adv_j) j_q <= CW'(j_q + 1'b1);
      acc_q  <= acc_d;
      best_q <= best_d;
    end else begin
      if (wr_x) x_cnt_q <= CW'(x_cnt_q + 1'b1);
      if (wr_y) y_cnt_q <= CW'(y_cnt_q + 1'b1);
      if (cmd_i.load && closes_vector_i) begin
        if (!which_vector_i) x_closed_q <= 1'b1;
        else                 y_closed_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && emit) begin
      oidx_q <= idx_w;
      oval_q <= sat_r[VW-1:0];
      sat_q  <= sat_r[VW];
      fin_q  <= fin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = oidx_q;
  assign out_value_o    = oval_q;
  assign saturated_o    = sat_q;
  assign final_result_o = fin_q;

endmodule

### rtl/core/sparse_vector_merge_engine.sv
`timescale 1ns / 1ps
// Loads accept one entry request per cycle; input stalls while a run is in progress.
// A run starts after the closing request; each merge step passes a store read, the
// registered multiplier and a step commit, and a commit that emits a result stalls
// until the output register can take it; a run has at most 2*DEPTH steps.
// Asynchronous active-low reset empties both vectors, mode 0, scale 1.0.
// ----------------------------------------------------------------------------
// sparse_vector_merge_engine
// Sparse dot product and scaled sum over two loaded vectors, infinity norm of the first.
// ----------------------------------------------------------------------------
module sparse_vector_merge_engine #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  svme_in_if.sink                   in_ch,
  svme_out_if.source                out_ch,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [svme_pkg::ValW-1:0] cfg_data_i
);

  svme_pkg::cmd_t    cmd;
  svme_pkg::status_t status;
  logic [svme_pkg::ValW-1:0] in_val, out_val;

  assign in_val           = in_ch.entry_value;
  assign out_ch.out_value = out_val;

  svme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svme_dp #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .which_vector_i  (in_ch.which_vector),
    .carries_entry_i (in_ch.carries_entry),
    .entry_index_i   (in_ch.entry_index),
    .entry_value_i   (in_val),
    .closes_vector_i (in_ch.closes_vector),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .out_index_o     (out_ch.out_index),
    .out_value_o     (out_val),
    .saturated_o     (out_ch.saturated),
    .final_result_o  (out_ch.final_result)
  );

endmodule
